[rtl/core/tct_pkg.sv]
// Shared types and constants for the three-channel target timer.
// Holds the command record passed from the decode front to the execute back.
// No dependencies.
package tct_pkg;

    localparam int unsigned CNT_W       = 16;
    localparam int unsigned CYC_W       = 10;
    localparam int unsigned OFFSET_W    = 6;
    localparam int unsigned TIMER_SEL_W = 2;
    localparam int unsigned OP_W        = 2;
    localparam int unsigned Q_DEPTH     = 4;
    localparam int unsigned Q_PTR_W     = 2;
    localparam int unsigned Q_CNT_W     = 3;

    // Mode word bit positions
    localparam int unsigned MODE_RESET_ON_TARGET = 3;
    localparam int unsigned MODE_IRQ             = 10;
    localparam int unsigned MODE_REACHED_TARGET  = 11;
    localparam int unsigned MODE_REACHED_FFFF    = 12;

    // Bus op codes as seen on the input tuser
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

    // Register offsets within one timer window
    localparam logic [3:0] OFS_COUNT  = 4'h0;
    localparam logic [3:0] OFS_MODE   = 4'h4;
    localparam logic [3:0] OFS_TARGET = 4'h8;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_READ,
        CMD_WRITE,
        CMD_ERROR
    } t_cmd_kind;

    typedef enum logic [1:0] {
        REG_COUNT,
        REG_MODE,
        REG_TARGET
    } t_reg_sel;

    typedef struct packed {
        t_cmd_kind               kind;
        t_reg_sel                reg_sel;
        logic [TIMER_SEL_W-1:0]  timer;
        logic [CNT_W-1:0]        data;
        logic [CYC_W-1:0]        cycles;
    } t_cmd;

endpackage

[rtl/core/tct_front.sv]
// Decode front of the target timer: accepts input transfers and classifies
// them into commands. Depends on tct_pkg.
module tct_front #(
    parameter int unsigned NUM_TIMERS = 3
) (
    input  logic                         i_valid,
    input  logic [tct_pkg::OP_W-1:0]     i_op,
    input  logic [tct_pkg::OFFSET_W-1:0] i_offset,
    input  logic [tct_pkg::CNT_W-1:0]    i_write_data,
    input  logic [tct_pkg::CYC_W-1:0]    i_tick_cycles,
    input  logic                         i_q_full,
    output logic                         o_ready,
    output logic                         o_push,
    output tct_pkg::t_cmd                o_cmd
);

    logic [tct_pkg::TIMER_SEL_W-1:0] timer;
    logic [3:0]                      reg_ofs;
    logic                            timer_ok;
    logic                            reg_ok;

    assign timer    = i_offset[tct_pkg::OFFSET_W-1:4];
    assign reg_ofs  = i_offset[3:0];
    assign timer_ok = ({1'b0, timer} < (tct_pkg::TIMER_SEL_W + 1)'(NUM_TIMERS));
    assign reg_ok   = (reg_ofs == tct_pkg::OFS_COUNT) || (reg_ofs == tct_pkg::OFS_MODE) ||
                      (reg_ofs == tct_pkg::OFS_TARGET);

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_cmd.timer  = timer;
        o_cmd.data   = i_write_data;
        o_cmd.cycles = i_tick_cycles;

        case (reg_ofs)
            tct_pkg::OFS_MODE:   o_cmd.reg_sel = tct_pkg::REG_MODE;
            tct_pkg::OFS_TARGET: o_cmd.reg_sel = tct_pkg::REG_TARGET;
            default:             o_cmd.reg_sel = tct_pkg::REG_COUNT;
        endcase

        case (i_op)
            tct_pkg::OP_TICK:  o_cmd.kind = tct_pkg::CMD_TICK;
            tct_pkg::OP_READ:  o_cmd.kind = (timer_ok && reg_ok) ? tct_pkg::CMD_READ
                                                                 : tct_pkg::CMD_ERROR;
            tct_pkg::OP_WRITE: o_cmd.kind = (timer_ok && reg_ok) ? tct_pkg::CMD_WRITE
                                                                 : tct_pkg::CMD_ERROR;
            default:           o_cmd.kind = tct_pkg::CMD_ERROR;
        endcase
    end

endmodule

[rtl/core/tct_queue.sv]
// Short command queue between the decode front and the execute back.
// Depends on tct_pkg.
module tct_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tct_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output tct_pkg::t_cmd o_cmd
);

    tct_pkg::t_cmd                 r_mem [tct_pkg::Q_DEPTH];
    logic [tct_pkg::Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [tct_pkg::Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [tct_pkg::Q_CNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == tct_pkg::Q_CNT_W'(tct_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/core/tct_back.sv]
// Execute back of the target timer: holds the counter, mode and target
// registers, runs ticks and bus accesses, and registers the result.
// Depends on tct_pkg.
module tct_back #(
    parameter int unsigned NUM_TIMERS = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_empty,
    input  tct_pkg::t_cmd             i_cmd,
    output logic                      o_pop,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [tct_pkg::CNT_W-1:0] o_read_data,
    output logic                      o_status
);

    localparam int unsigned CW = tct_pkg::CNT_W;

    logic [CW-1:0] r_count  [NUM_TIMERS];
    logic [CW-1:0] r_target [NUM_TIMERS];
    logic [CW-1:0] r_mode   [NUM_TIMERS];
    logic [CW-1:0] n_count  [NUM_TIMERS];
    logic [CW-1:0] n_target [NUM_TIMERS];
    logic [CW-1:0] n_mode   [NUM_TIMERS];

    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] r_read_data, n_read_data;
    logic          r_status, n_status;

    logic [CW:0]   sum      [NUM_TIMERS];
    logic [CW-1:0] mode_t   [NUM_TIMERS];

    // Take a command whenever the output register is free or draining
    assign o_pop = !i_q_empty && (!r_out_valid || i_out_ready);

    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            // Tick path per lane: 17-bit sum, target compare, then wrap check
            sum[i]    = {1'b0, r_count[i]} + (CW + 1)'(i_cmd.cycles);
            mode_t[i] = r_mode[i];
            if (sum[i] > {1'b0, r_target[i]}) begin
                mode_t[i][tct_pkg::MODE_REACHED_TARGET] = 1'b1;
                if (r_mode[i][tct_pkg::MODE_RESET_ON_TARGET]) begin
                    sum[i] = '0;
                end
            end
            if (sum[i][CW]) begin
                mode_t[i][tct_pkg::MODE_REACHED_FFFF] = 1'b1;
                if (!r_mode[i][tct_pkg::MODE_RESET_ON_TARGET]) begin
                    sum[i] = '0;
                end
            end

            n_count[i]  = r_count[i];
            n_target[i] = r_target[i];
            n_mode[i]   = r_mode[i];

            if (o_pop) begin
                case (i_cmd.kind)
                    tct_pkg::CMD_TICK: begin
                        n_count[i] = sum[i][CW-1:0];
                        n_mode[i]  = mode_t[i];
                    end
                    tct_pkg::CMD_READ: begin
                        if (i_cmd.timer == tct_pkg::TIMER_SEL_W'(i) &&
                            i_cmd.reg_sel == tct_pkg::REG_MODE) begin
                            n_mode[i][tct_pkg::MODE_REACHED_TARGET] = 1'b0;
                            n_mode[i][tct_pkg::MODE_REACHED_FFFF]   = 1'b0;
                        end
                    end
                    tct_pkg::CMD_WRITE: begin
                        if (i_cmd.timer == tct_pkg::TIMER_SEL_W'(i)) begin
                            case (i_cmd.reg_sel)
                                tct_pkg::REG_COUNT: n_count[i] = i_cmd.data;
                                tct_pkg::REG_MODE: begin
                                    n_count[i] = '0;
                                    n_mode[i]  = i_cmd.data;
                                    n_mode[i][tct_pkg::MODE_IRQ] = 1'b1;
                                end
                                tct_pkg::REG_TARGET: n_target[i] = i_cmd.data;
                                default: ;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_read_data = r_read_data;
        n_status    = r_status;
        if (o_pop) begin
            n_out_valid = 1'b1;
            n_read_data = '0;
            n_status    = (i_cmd.kind == tct_pkg::CMD_ERROR);
            if (i_cmd.kind == tct_pkg::CMD_READ) begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (i_cmd.timer == tct_pkg::TIMER_SEL_W'(i)) begin
                        case (i_cmd.reg_sel)
                            tct_pkg::REG_MODE:   n_read_data = r_mode[i];
                            tct_pkg::REG_TARGET: n_read_data = r_target[i];
                            default:             n_read_data = r_count[i];
                        endcase
                    end
                end
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_count[i]  <= '0;
                r_target[i] <= '0;
                r_mode[i]   <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_count[i]  <= n_count[i];
                r_target[i] <= n_target[i];
                r_mode[i]   <= n_mode[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_data <= n_read_data;
        r_status    <= n_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_status    = r_status;

endmodule

[rtl/core/three_channel_target_timer_unit.sv]
// Three-channel target timer: up to four 16-bit counters with mode words
// and targets, driven by tick and bus read/write commands.
// Depends on tct_pkg, tct_front, tct_queue and tct_back.
//
// Each input transfer is a tick (adds tick_cycles to every counter) or a
// bus access to offset 0 (counter), 4 (mode) or 8 (target) of a 16-byte
// window per timer; every input gives exactly one result transfer carrying
// read data and an error status. The block takes one transfer per clock
// while the queue is not full: the front decodes in the accept cycle into
// a four-entry command queue, and the back executes one command per cycle,
// while the output register is free or draining, into that register. All
// timer lanes update in parallel on a tick with one 17-bit add and compare each.
module three_channel_target_timer_unit #(
    parameter int unsigned NUM_TIMERS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // offset[5:0], write_data[21:6], tick_cycles[31:22]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // read_data[15:0]
    output logic        m_axis_tuser    // status[0]
);

    tct_pkg::t_cmd front_cmd;
    tct_pkg::t_cmd back_cmd;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    tct_front #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_front (
        .i_valid       (s_axis_tvalid),
        .i_op          (s_axis_tuser),
        .i_offset      (s_axis_tdata[5:0]),
        .i_write_data  (s_axis_tdata[21:6]),
        .i_tick_cycles (s_axis_tdata[31:22]),
        .i_q_full      (q_full),
        .o_ready       (s_axis_tready),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    tct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (back_cmd)
    );

    tct_back #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cmd       (back_cmd),
        .o_pop       (pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_read_data (m_axis_tdata),
        .o_status    (m_axis_tuser)
    );

endmodule

[tb/tb_three_channel_target_timer_unit.sv]
// Testbench for three_channel_target_timer_unit: directed and random ticks, bus reads and
// bus writes, checked result by result against an in-bench model of counters, modes, targets.
// Depends on tct_pkg and the timer unit RTL.
module tb_three_channel_target_timer_unit;

    localparam int unsigned TIMERS      = 3;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam logic [tct_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] read_data;
        logic        status;
    } t_access_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // offset[5:0], write_data[21:6], tick_cycles[31:22]
    logic [1:0]  s_axis_tuser  = '0;    // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // read_data[15:0]
    logic        m_axis_tuser;          // status[0]

    logic [15:0]    mdl_count  [TIMERS];
    logic [15:0]    mdl_target [TIMERS];
    logic [15:0]    mdl_mode   [TIMERS];
    t_access_result pending_results [$];
    t_access_result oldest;

    int err_count    = 0;
    int cycle_count  = 0;
    bit send_idle    = 1'b1;
    bit recv_idle    = 1'b1;
    bit out_of_reset = 1'b0;

    three_channel_target_timer_unit #(.NUM_TIMERS(TIMERS)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < TIMERS; i++) begin
            mdl_count[i]  = '0;
            mdl_target[i] = '0;
            mdl_mode[i]   = '0;
        end
    end

    // Update the timer model for one accepted transfer and queue its result.
    function automatic void predict_access(logic [1:0] op, logic [5:0] ofs,
                                           logic [15:0] wdata, logic [9:0] cyc);
        t_access_result res;
        logic [16:0]    sum;
        logic [15:0]    m;
        int unsigned    t;
        logic [3:0]     rsel;
        bit             good;
        res  = '0;
        t    = ofs[5:4];
        rsel = ofs[3:0];
        good = (t < TIMERS) &&
               (rsel == tct_pkg::OFS_COUNT || rsel == tct_pkg::OFS_MODE ||
                rsel == tct_pkg::OFS_TARGET);
        case (op)
            tct_pkg::OP_TICK: begin
                for (int i = 0; i < TIMERS; i++) begin
                    sum = {1'b0, mdl_count[i]} + {7'd0, cyc};
                    m   = mdl_mode[i];
                    // strict compare against the target
                    if (sum > {1'b0, mdl_target[i]}) begin
                        m[tct_pkg::MODE_REACHED_TARGET] = 1'b1;
                        if (m[tct_pkg::MODE_RESET_ON_TARGET]) sum = '0;
                    end
                    if (sum > 17'h0FFFF) begin
                        m[tct_pkg::MODE_REACHED_FFFF] = 1'b1;
                        if (!m[tct_pkg::MODE_RESET_ON_TARGET]) sum = '0;
                    end
                    mdl_mode[i]  = m;
                    mdl_count[i] = sum[15:0];
                end
            end
            tct_pkg::OP_READ: begin
                if (!good) begin
                    res.status = 1'b1;
                end else if (rsel == tct_pkg::OFS_COUNT) begin
                    res.read_data = mdl_count[t];
                end else if (rsel == tct_pkg::OFS_MODE) begin
                    res.read_data = mdl_mode[t];
                    mdl_mode[t][tct_pkg::MODE_REACHED_TARGET] = 1'b0;
                    mdl_mode[t][tct_pkg::MODE_REACHED_FFFF]   = 1'b0;
                end else begin
                    res.read_data = mdl_target[t];
                end
            end
            tct_pkg::OP_WRITE: begin
                if (!good) begin
                    res.status = 1'b1;
                end else if (rsel == tct_pkg::OFS_COUNT) begin
                    mdl_count[t] = wdata;
                end else if (rsel == tct_pkg::OFS_MODE) begin
                    mdl_count[t]                   = '0;
                    mdl_mode[t]                    = wdata;
                    mdl_mode[t][tct_pkg::MODE_IRQ] = 1'b1;
                end else begin
                    mdl_target[t] = wdata;
                end
            end
            default: res.status = 1'b1;
        endcase
        pending_results.push_back(res);
    endfunction

    function automatic logic [9:0] rand_cycles();
        case ($urandom_range(0, 5))
            0:       return 10'd0;
            1:       return 10'h3FF;
            2:       return 10'($urandom_range(0, 16));
            default: return 10'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        err_count++;
    endtask

    // Send one transfer; returns at the edge where it is accepted.
    task automatic send_item(logic [1:0] op, logic [5:0] ofs, logic [15:0] wdata,
                             logic [9:0] cyc);
        int gap;
        gap = send_idle ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cyc, wdata, ofs};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_access(op, ofs, wdata, cyc);
    endtask

    task automatic bus_write(logic [1:0] t, logic [3:0] rsel, logic [15:0] wdata);
        send_item(tct_pkg::OP_WRITE, {t, rsel}, wdata, 10'($urandom));
    endtask

    task automatic bus_read(logic [1:0] t, logic [3:0] rsel);
        send_item(tct_pkg::OP_READ, {t, rsel}, 16'($urandom), 10'($urandom));
    endtask

    task automatic tick(logic [9:0] cyc);
        send_item(tct_pkg::OP_TICK, 6'($urandom), 16'($urandom), cyc);
    endtask

    task automatic send_noise();
        send_item(2'($urandom), 6'($urandom), 16'($urandom), 10'($urandom));
    endtask

    // Hold off the sender until every queued result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_directed();
        // reset values
        bus_read(2'd0, tct_pkg::OFS_COUNT);
        bus_read(2'd1, tct_pkg::OFS_MODE);
        bus_read(2'd2, tct_pkg::OFS_TARGET);
        // unused op, bad register offsets, timer beyond the last one
        send_item(OP_UNUSED, 6'h00, 16'hFFFF, 10'h3FF);
        bus_read(2'd0, 4'h2);
        bus_write(2'd1, 4'hF, 16'hFFFF);
        bus_read(2'd3, tct_pkg::OFS_COUNT);
        bus_write(2'd3, tct_pkg::OFS_TARGET, 16'h1234);
        // count equal to target does not reach it
        bus_write(2'd0, tct_pkg::OFS_TARGET, 16'd5);
        bus_write(2'd0, tct_pkg::OFS_COUNT, 16'd5);
        tick(10'd0);
        bus_read(2'd0, tct_pkg::OFS_MODE);
        tick(10'd1);
        bus_read(2'd0, tct_pkg::OFS_MODE);
        bus_read(2'd0, tct_pkg::OFS_MODE);
        // reset-on-target clears the counter; mode write forces irq
        bus_write(2'd1, tct_pkg::OFS_MODE, 16'h0008);
        bus_write(2'd1, tct_pkg::OFS_TARGET, 16'h0100);
        tick(10'h3FF);
        bus_read(2'd1, tct_pkg::OFS_COUNT);
        bus_read(2'd1, tct_pkg::OFS_MODE);
        // wrap past 0xFFFF
        bus_write(2'd2, tct_pkg::OFS_TARGET, 16'hFFFF);
        bus_write(2'd2, tct_pkg::OFS_COUNT, 16'hFFFF);
        tick(10'd1);
        bus_read(2'd2, tct_pkg::OFS_MODE);
        bus_write(2'd0, tct_pkg::OFS_MODE, 16'hFFFF);
        bus_read(2'd0, tct_pkg::OFS_MODE);
    endtask

    task automatic test_noise(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0) begin
                send_idle = $urandom_range(0, 2) != 0;
                recv_idle = $urandom_range(0, 2) != 0;
            end
            send_noise();
        end
    endtask

    // Program one timer, then tick it toward its target with reads in between.
    task automatic test_sequences(int n);
        int          sent;
        logic [1:0]  t;
        logic [15:0] tgt;
        logic [15:0] mode;
        int          ticks;
        sent = 0;
        while (sent < n) begin
            send_idle = $urandom_range(0, 3) != 0;
            recv_idle = $urandom_range(0, 3) != 0;
            t = 2'($urandom_range(0, TIMERS - 1));
            case ($urandom_range(0, 3))
                0:       tgt = 16'($urandom_range(0, 64));
                1:       tgt = 16'($urandom_range(0, 2047));
                2:       tgt = 16'($urandom);
                default: tgt = 16'hFFFF;
            endcase
            mode = 16'($urandom);
            bus_write(t, tct_pkg::OFS_TARGET, tgt);
            bus_write(t, tct_pkg::OFS_MODE, mode);
            sent += 2;
            if ($urandom_range(0, 1)) begin
                if ($urandom_range(0, 1))
                    bus_write(t, tct_pkg::OFS_COUNT, 16'hFFFF - 16'($urandom_range(0, 1500)));
                else
                    bus_write(t, tct_pkg::OFS_COUNT, tgt - 16'($urandom_range(0, 1500)));
                sent++;
            end
            ticks = $urandom_range(1, 6);
            for (int k = 0; k < ticks; k++) begin
                tick(rand_cycles());
                sent++;
                if ($urandom_range(0, 2) != 0) begin
                    bus_read(($urandom_range(0, 2) != 0) ? t : 2'($urandom_range(0, 2)),
                             $urandom_range(0, 1) ? tct_pkg::OFS_MODE :
                             ($urandom_range(0, 1) ? tct_pkg::OFS_COUNT
                                                   : tct_pkg::OFS_TARGET));
                    sent++;
                end
            end
            if ($urandom_range(0, 7) == 0) begin
                send_noise();
                sent++;
            end
        end
    endtask

    // Back-to-back transfers with no idling on either side.
    task automatic test_streaming(int n);
        logic [3:0] rsel;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 2))
                0:       rsel = tct_pkg::OFS_COUNT;
                1:       rsel = tct_pkg::OFS_MODE;
                default: rsel = tct_pkg::OFS_TARGET;
            endcase
            case ($urandom_range(0, 2))
                0:       tick(rand_cycles());
                1:       bus_read(2'($urandom_range(0, TIMERS - 1)), rsel);
                default: bus_write(2'($urandom_range(0, TIMERS - 1)), rsel,
                                   (rsel == tct_pkg::OFS_TARGET) ? 16'($urandom_range(0, 3000))
                                                                 : 16'($urandom));
            endcase
        end
    endtask

    // Result side: draw a stall per transfer, then wait for the transfer.
    initial begin
        int gap;
        wait (out_of_reset);
        @(posedge i_clk);
        forever begin
            gap = recv_idle ? $urandom_range(0, 18) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (out_of_reset && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, read_data", m_axis_tdata, 16'h0);
            end else begin
                oldest = pending_results.pop_front();
                if (m_axis_tdata !== oldest.read_data)
                    report_mismatch("read_data", m_axis_tdata, oldest.read_data);
                if (m_axis_tuser !== oldest.status)
                    report_mismatch("status", {15'd0, m_axis_tuser}, {15'd0, oldest.status});
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n      <= 1'b1;
        out_of_reset <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_for_results();
        test_noise(300);
        wait_for_results();
        test_sequences(800);
        wait_for_results();
        test_streaming(200);
        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
